[src/epdm_pkg.sv]
package epdm_pkg;

  // Field widths of the request, result and configuration port.
  localparam int unsigned CAP_W       = 16;
  localparam int unsigned OVF_W       = 16;
  localparam int unsigned RELOAD_W    = 16;
  localparam int unsigned PRESCALE_W  = 16;
  localparam int unsigned CLK_MHZ_W   = 10;
  localparam int unsigned DIST_W      = 35;
  localparam int unsigned TICKS_W     = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Default width of the hardware timer counter.
  localparam int unsigned COUNTER_BITS_DEF = 16;

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // 0.017 cm per microsecond in Q8 is exactly 4352 / 1000.
  localparam int unsigned Q8_NUM = 4352;
  localparam int unsigned Q8_DEN = 1000;

  // Configuration reset values.
  localparam logic [RELOAD_W-1:0]   RELOAD_RST   = 16'hFFFF;
  localparam logic [PRESCALE_W-1:0] PRESCALE_RST = 16'd0;
  localparam logic [CLK_MHZ_W-1:0]  CLK_MHZ_RST  = 10'd72;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RELOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLK    = 2'd2;

  // Operation codes of an input request.
  localparam logic OP_CAPTURE  = 1'b0;
  localparam logic OP_OVERFLOW = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [CAP_W-1:0] capture_value;
  } in_req_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance_q8;
    logic [TICKS_W-1:0] echo_ticks;
    logic               divide_error;
  } out_res_t;

  typedef struct packed {
    logic [RELOAD_W-1:0]   timer_reload;
    logic [PRESCALE_W-1:0] prescaler;
    logic [CLK_MHZ_W-1:0]  timer_clk_mhz;
  } cfg_t;

  // One complete echo measurement handed from the front to the back.
  typedef struct packed {
    logic [CAP_W-1:0] fall_cap;
    logic [CAP_W-1:0] rise_cap;
    logic [OVF_W-1:0] ovf;
  } job_t;

endpackage

[src/epdm_front.sv]
module epdm_front #(
  parameter int unsigned COUNTER_BITS = epdm_pkg::COUNTER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  epdm_pkg::in_req_t in_req,
  output logic             push_valid,
  output epdm_pkg::job_t   push_job,
  input  logic             queue_full
);

  // Only the low counter bits of a capture are meaningful.
  localparam int unsigned CapBits =
      (COUNTER_BITS < epdm_pkg::CAP_W) ? COUNTER_BITS : epdm_pkg::CAP_W;

  logic                        awaiting_r;
  logic [CapBits-1:0]          rise_r;
  logic [epdm_pkg::OVF_W-1:0]  ovf_r;
  logic [CapBits-1:0]          cap_m;
  logic                        accept;
  logic                        is_fall;

  assign cap_m    = CapBits'(in_req.capture_value);
  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign is_fall  = (in_req.operation == epdm_pkg::OP_CAPTURE) && awaiting_r;

  // A falling edge hands the whole measurement to the queue.
  assign push_valid        = accept && is_fall;
  assign push_job.fall_cap = epdm_pkg::CAP_W'(cap_m);
  assign push_job.rise_cap = epdm_pkg::CAP_W'(rise_r);
  assign push_job.ovf      = ovf_r;

  // Edge state and overflow counting.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      rise_r     <= '0;
      ovf_r      <= '0;
    end else if (accept) begin
      if (in_req.operation == epdm_pkg::OP_OVERFLOW) begin
        ovf_r <= ovf_r + 1'b1;
      end else if (!awaiting_r) begin
        rise_r     <= cap_m;
        awaiting_r <= 1'b1;
        ovf_r      <= '0;
      end else begin
        awaiting_r <= 1'b0;
      end
    end
  end

endmodule

[src/epdm_queue.sv]
module epdm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  epdm_pkg::job_t wr_job,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output epdm_pkg::job_t rd_job
);

  localparam int unsigned Depth  = epdm_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  epdm_pkg::job_t    mem [Depth];
  logic [PtrW-1:0]   wr_ptr_r;
  logic [PtrW-1:0]   rd_ptr_r;
  logic [CountW-1:0] count_r;

  assign full     = (count_r == CountW'(Depth));
  assign rd_valid = (count_r != '0);
  assign rd_job   = mem[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // The front never writes a full queue and the back never reads an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (count_r != CountW'(Depth)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (count_r != '0))
    else $error("queue read while empty");

endmodule

[src/epdm_back.sv]
module epdm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  epdm_pkg::cfg_t     cfg,
  input  logic               job_valid,
  input  epdm_pkg::job_t     job,
  output logic               job_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output epdm_pkg::out_res_t out_res
);

  localparam int unsigned PerW    = epdm_pkg::CLK_MHZ_W;
  localparam int unsigned DivW    = epdm_pkg::PRESCALE_W + 1;
  localparam int unsigned ProdW   = epdm_pkg::TICKS_W + $clog2(epdm_pkg::Q8_NUM + 1);
  localparam int unsigned DenW    = PerW + $clog2(epdm_pkg::Q8_DEN + 1);
  localparam int unsigned StepW   = $clog2(ProdW);
  localparam int unsigned TicksW  = epdm_pkg::TICKS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXT,
    S_TICKS,
    S_PDIV,
    S_SCALE,
    S_QDIV,
    S_OUT
  } state_t;

  state_t              state_r;
  epdm_pkg::job_t      job_r;
  logic [TicksW-1:0]   ext_r;
  logic [TicksW-1:0]   ticks_r;
  logic [PerW-1:0]     pd_q_r;
  logic [PerW-1:0]     pd_rem_r;
  logic [ProdW-1:0]    qd_q_r;
  logic [DenW-1:0]     qd_rem_r;
  logic [DenW-1:0]     den_r;
  logic                err_r;
  logic [StepW-1:0]    step_r;
  logic                out_valid_r;
  epdm_pkg::out_res_t  out_r;

  logic [DivW-1:0]     period;
  logic [DivW-1:0]     psc_div;
  logic [PerW:0]       pd_sh;
  logic                pd_ge;
  logic [DenW:0]       qd_sh;
  logic                qd_ge;
  logic                out_free;
  logic                out_load;

  assign period   = DivW'(cfg.timer_reload) + DivW'(1);
  assign psc_div  = DivW'(cfg.prescaler) + DivW'(1);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_OUT) && out_free;
  assign job_pop  = (state_r == S_IDLE) && job_valid;

  // One restoring step of the timer clock / (prescaler + 1).
  assign pd_sh = {pd_rem_r, pd_q_r[PerW-1]};
  assign pd_ge = (DivW'(pd_sh) >= psc_div);

  // One restoring step of ticks * 4352 / (1000 * ticks per microsecond).
  assign qd_sh = {qd_rem_r, qd_q_r[ProdW-1]};
  assign qd_ge = (qd_sh >= {1'b0, den_r});

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // Sequencer: edge extension, prescale divide, scaling, long divide, result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            job_r   <= job;
            state_r <= S_EXT;
          end
        end
        S_EXT: begin
          ext_r   <= TicksW'((DivW + epdm_pkg::OVF_W)'(job_r.ovf) *
                             (DivW + epdm_pkg::OVF_W)'(period));
          state_r <= S_TICKS;
        end
        S_TICKS: begin
          ticks_r  <= TicksW'(job_r.fall_cap) + ext_r - TicksW'(job_r.rise_cap);
          pd_q_r   <= cfg.timer_clk_mhz;
          pd_rem_r <= '0;
          step_r   <= '0;
          state_r  <= S_PDIV;
        end
        S_PDIV: begin
          pd_rem_r <= pd_ge ? PerW'(DivW'(pd_sh) - psc_div) : pd_sh[PerW-1:0];
          pd_q_r   <= {pd_q_r[PerW-2:0], pd_ge};
          step_r   <= step_r + 1'b1;
          if (step_r == StepW'(PerW - 1)) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          qd_q_r   <= ProdW'(ticks_r) * ProdW'(epdm_pkg::Q8_NUM);
          den_r    <= DenW'(pd_q_r) * DenW'(epdm_pkg::Q8_DEN);
          err_r    <= (pd_q_r == '0);
          qd_rem_r <= '0;
          step_r   <= '0;
          state_r  <= (pd_q_r == '0) ? S_OUT : S_QDIV;
        end
        S_QDIV: begin
          qd_rem_r <= qd_ge ? DenW'(qd_sh - {1'b0, den_r}) : qd_sh[DenW-1:0];
          qd_q_r   <= {qd_q_r[ProdW-2:0], qd_ge};
          step_r   <= step_r + 1'b1;
          if (step_r == StepW'(ProdW - 1)) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_r.distance_q8  <= err_r ? '0 : qd_q_r[epdm_pkg::DIST_W-1:0];
            out_r.echo_ticks   <= ticks_r;
            out_r.divide_error <= err_r;
            state_r            <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // A new result carries the error flag exactly when the rate divisor was zero.
  a_err_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_r.divide_error == (den_r == '0)))
    else $error("divide error flag disagrees with divisor");

  // An error result always reports zero distance.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.divide_error) |-> (out_r.distance_q8 == '0))
    else $error("nonzero distance with divide error");

endmodule

[src/echo_pulse_distance_meter.sv]
// Echo pulse distance meter on a timer with input capture.
// Requests arrive on in_valid / in_stall / in_req: operation selects a timer
// overflow tick or a capture edge carrying the latched count. The rising
// edge stores the stamp and clears the overflow count; the falling edge yields a
// result on out_valid / out_stall / out_res with the echo width in ticks and
// the distance in centimeters with eight fraction bits.
// Overflow ticks and rising edges are taken by the front and give no
// result. A falling edge is queued (two entries); the back picks it up,
// extends the edge by the overflow count, runs the prescale divide, scales,
// runs the bit-serial distance divide and loads the output register. A
// zero divisor skips the long divide. The back takes a new falling edge
// only after the last result has been loaded into the output register.
// Configuration registers are written on cfg_valid / cfg_ready with cfg_index
// and cfg_data; cfg_ready is always high and writes belong to idle periods.
// Reset clears the edge state, the queue and the output valid, and loads the
// register defaults. When the receiver stalls, the result holds in the output
// register, the back waits, and the front keeps taking requests until the
// queue fills, at which point in_stall rises.
module echo_pulse_distance_meter #(
  parameter int unsigned COUNTER_BITS = epdm_pkg::COUNTER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  epdm_pkg::in_req_t                   in_req,
  output logic                                out_valid,
  input  logic                                out_stall,
  output epdm_pkg::out_res_t                  out_res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [epdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [epdm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  epdm_pkg::cfg_t cfg_r;
  logic           push_valid;
  epdm_pkg::job_t push_job;
  logic           queue_full;
  logic           pop;
  logic           pop_valid;
  epdm_pkg::job_t pop_job;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timer_reload  <= epdm_pkg::RELOAD_RST;
      cfg_r.prescaler     <= epdm_pkg::PRESCALE_RST;
      cfg_r.timer_clk_mhz <= epdm_pkg::CLK_MHZ_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        epdm_pkg::CFG_TIMER_RELOAD: cfg_r.timer_reload  <= cfg_data;
        epdm_pkg::CFG_PRESCALER:    cfg_r.prescaler     <= cfg_data;
        epdm_pkg::CFG_TIMER_CLK:    cfg_r.timer_clk_mhz <=
                                      cfg_data[epdm_pkg::CLK_MHZ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  epdm_front #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .push_valid (push_valid),
    .push_job   (push_job),
    .queue_full (queue_full)
  );

  epdm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push_valid),
    .wr_job   (push_job),
    .full     (queue_full),
    .rd_en    (pop),
    .rd_valid (pop_valid),
    .rd_job   (pop_job)
  );

  epdm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (pop_valid),
    .job       (pop_job),
    .job_pop   (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule
